[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the triad attitude checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert with the reset as disable condition
`define TAM_ASSERT_R(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tam assertion failed");

// assert on every edge, reset included
`define TAM_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tam assertion failed");

`endif

[sv/tam_pkg.sv]
// ----------------------------------------------------------------------------
// tam_pkg
// Shared constants and types of the triad attitude matrix datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tam_pkg;

   localparam int MANT_BITS   = 30;
   localparam int NORM_STAGES = 6;
   localparam int SQ_BITS     = 62;
   localparam int ROOT_BITS   = 31;
   localparam int ROOT_STAGES = 31;

   typedef struct packed {
      logic valid;
      logic deg;
   } tam_stat_type;

endpackage

[sv/tam_req_if.sv]
// ----------------------------------------------------------------------------
// tam_req_if
// Request channel: one set of reference and measured direction vectors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tam_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] ref_sun_x;
   logic signed [DATA_WIDTH-1:0] ref_sun_y;
   logic signed [DATA_WIDTH-1:0] ref_sun_z;
   logic signed [DATA_WIDTH-1:0] ref_mag_x;
   logic signed [DATA_WIDTH-1:0] ref_mag_y;
   logic signed [DATA_WIDTH-1:0] ref_mag_z;
   logic signed [DATA_WIDTH-1:0] meas_sun_x;
   logic signed [DATA_WIDTH-1:0] meas_sun_y;
   logic signed [DATA_WIDTH-1:0] meas_sun_z;
   logic signed [DATA_WIDTH-1:0] meas_mag_x;
   logic signed [DATA_WIDTH-1:0] meas_mag_y;
   logic signed [DATA_WIDTH-1:0] meas_mag_z;

   modport source (
      output valid, ref_sun_x, ref_sun_y, ref_sun_z, ref_mag_x, ref_mag_y, ref_mag_z,
      output meas_sun_x, meas_sun_y, meas_sun_z, meas_mag_x, meas_mag_y, meas_mag_z,
      input  ready
   );
   modport sink (
      input  valid, ref_sun_x, ref_sun_y, ref_sun_z, ref_mag_x, ref_mag_y, ref_mag_z,
      input  meas_sun_x, meas_sun_y, meas_sun_z, meas_mag_x, meas_mag_y, meas_mag_z,
      output ready
   );
endinterface

[sv/tam_rsp_if.sv]
// ----------------------------------------------------------------------------
// tam_rsp_if
// Response channel: attitude matrix and degenerate flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tam_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] a00;
   logic signed [DATA_WIDTH-1:0] a01;
   logic signed [DATA_WIDTH-1:0] a02;
   logic signed [DATA_WIDTH-1:0] a10;
   logic signed [DATA_WIDTH-1:0] a11;
   logic signed [DATA_WIDTH-1:0] a12;
   logic signed [DATA_WIDTH-1:0] a20;
   logic signed [DATA_WIDTH-1:0] a21;
   logic signed [DATA_WIDTH-1:0] a22;
   logic                         degenerate;

   modport source (
      output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, degenerate,
      input  ready
   );
   modport sink (
      input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, degenerate,
      output ready
   );
endinterface

[sv/triad_attitude_matrix_top.sv]
// ----------------------------------------------------------------------------
// triad_attitude_matrix_top
// TRIAD attitude matrix A = Mo * transpose(Mr) from measured and reference
// magnetic and sun directions, signed fixed point, saturated.
// The square root and divider in each frame resolve one bit per pipeline stage.
// Throughput: one transaction per cycle while the response side keeps up; a
// two-entry output stage absorbs stalls, and ready drops once both are full.
// Reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triad_attitude_matrix_top
   import tam_pkg::*;
#(
   parameter int DATA_WIDTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   tam_req_if.sink     req_chan,
   tam_rsp_if.source   rsp_chan
);

   localparam int W    = DATA_WIDTH;
   localparam int F    = W - 2;
   localparam int PW   = 2 * W;
   localparam int RMW  = PW + 1 - F;
   localparam int SUMW = W + 6;
   localparam logic [SUMW-1:0] SMAX = {{(SUMW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [SUMW-1:0] SMIN = {{(SUMW - W + 1){1'b1}}, {(W - 1){1'b0}}};
   localparam logic [PW:0] HALF = (PW + 1)'(1) << (F - 1);

   logic en;
   logic out_v_ff, skid_v_ff;

   assign en             = !skid_v_ff;
   assign req_chan.ready = en;

   logic [2:0][W-1:0] mo1, mo2, mo3, mr1, mr2, mr3;
   tam_stat_type      mo_stat, mr_stat;

   tam_frame #(.DATA_WIDTH(DATA_WIDTH)) u_meas (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .m_vec    ({req_chan.meas_mag_z, req_chan.meas_mag_y, req_chan.meas_mag_x}),
      .s_vec    ({req_chan.meas_sun_z, req_chan.meas_sun_y, req_chan.meas_sun_x}),
      .col1     (mo1),
      .col2     (mo2),
      .col3     (mo3),
      .stat     (mo_stat)
   );

   tam_frame #(.DATA_WIDTH(DATA_WIDTH)) u_ref (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .m_vec    ({req_chan.ref_mag_z, req_chan.ref_mag_y, req_chan.ref_mag_x}),
      .s_vec    ({req_chan.ref_sun_z, req_chan.ref_sun_y, req_chan.ref_sun_x}),
      .col1     (mr1),
      .col2     (mr2),
      .col3     (mr3),
      .stat     (mr_stat)
   );

   logic [2:0][2:0][W-1:0] mo_c, mr_c;
   logic signed [PW-1:0]   mp_in [27];
   logic signed [PW-1:0]   mp_ff [27];
   logic [2:0]             tv_ff;
   logic [2:0]             dg_ff;

   assign mo_c = {mo3, mo2, mo1};
   assign mr_c = {mr3, mr2, mr1};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               mp_in[(i*3 + j)*3 + k] = $signed(mo_c[k][i]) * $signed(mr_c[k][j]);
            end
         end
      end
   end

   // round each product, then sum
   logic [PW-1:0]          pmag;
   logic [PW:0]            psum;
   logic signed [RMW:0]    pr;
   logic signed [SUMW-1:0] acc_in [9];
   logic signed [SUMW-1:0] acc_ff [9];

   always_comb begin
      for (int e = 0; e < 9; e++) begin
         acc_in[e] = '0;
         for (int k = 0; k < 3; k++) begin
            pmag = $unsigned(mp_ff[e*3 + k][PW-1] ? -mp_ff[e*3 + k] : mp_ff[e*3 + k]);
            psum = (PW + 1)'(pmag) + HALF;
            pr   = $signed((RMW + 1)'(psum >> F));
            if (mp_ff[e*3 + k][PW-1]) begin
               pr = -pr;
            end
            acc_in[e] = acc_in[e] + SUMW'(pr);
         end
      end
   end

   logic [8:0][W-1:0] sat_in;
   logic [8:0][W-1:0] last_ff;

   always_comb begin
      for (int e = 0; e < 9; e++) begin
         if (dg_ff[1]) begin
            sat_in[e] = '0;
         end else if (acc_ff[e] > $signed(SMAX)) begin
            sat_in[e] = SMAX[W-1:0];
         end else if (acc_ff[e] < $signed(SMIN)) begin
            sat_in[e] = SMIN[W-1:0];
         end else begin
            sat_in[e] = acc_ff[e][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= '0;
      end else if (en) begin
         tv_ff <= {tv_ff[1:0], mo_stat.valid & mr_stat.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff   <= mp_in;
         acc_ff  <= acc_in;
         last_ff <= sat_in;
         dg_ff   <= {dg_ff[1:0], mo_stat.deg | mr_stat.deg};
      end
   end

   // output register with skid entry
   logic [8:0][W-1:0] out_ff, skid_ff;
   logic              out_d_ff, skid_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (skid_v_ff) begin
            if (rsp_chan.ready) begin
               skid_v_ff <= 1'b0;
            end
         end else if (tv_ff[2]) begin
            if (!out_v_ff || rsp_chan.ready) begin
               out_v_ff <= 1'b1;
            end else begin
               skid_v_ff <= 1'b1;
            end
         end else if (rsp_chan.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_chan.ready) begin
            out_ff   <= skid_ff;
            out_d_ff <= skid_d_ff;
         end
      end else if (tv_ff[2]) begin
         if (!out_v_ff || rsp_chan.ready) begin
            out_ff   <= last_ff;
            out_d_ff <= dg_ff[2];
         end else begin
            skid_ff   <= last_ff;
            skid_d_ff <= dg_ff[2];
         end
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.a00        = out_ff[0];
   assign rsp_chan.a01        = out_ff[1];
   assign rsp_chan.a02        = out_ff[2];
   assign rsp_chan.a10        = out_ff[3];
   assign rsp_chan.a11        = out_ff[4];
   assign rsp_chan.a12        = out_ff[5];
   assign rsp_chan.a20        = out_ff[6];
   assign rsp_chan.a21        = out_ff[7];
   assign rsp_chan.a22        = out_ff[8];
   assign rsp_chan.degenerate = out_d_ff;

endmodule

[sv/tam_frame.sv]
// ----------------------------------------------------------------------------
// tam_frame
// Pipelined TRIAD frame: cross product, normalisation, square root,
// division and second cross product, giving the three frame columns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tam_frame
   import tam_pkg::*;
#(
   parameter int DATA_WIDTH = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [2:0][DATA_WIDTH-1:0] m_vec,
   input  logic [2:0][DATA_WIDTH-1:0] s_vec,
   output logic [2:0][DATA_WIDTH-1:0] col1,
   output logic [2:0][DATA_WIDTH-1:0] col2,
   output logic [2:0][DATA_WIDTH-1:0] col3,
   output tam_stat_type               stat
);

   localparam int W     = DATA_WIDTH;
   localparam int F     = W - 2;
   localparam int PW    = 2 * W;
   localparam int CW    = 2 * W + 1;
   localparam int XW    = (CW > MANT_BITS) ? CW : MANT_BITS;
   localparam int QW    = F + 1;
   localparam int DVW   = ROOT_BITS + F;
   localparam int SIDEW = 3 * W + 4;
   localparam int SIDX  = NORM_STAGES + 3 + ROOT_STAGES + QW;
   localparam int LAT   = NORM_STAGES + ROOT_STAGES + QW + 8;
   localparam int RNW   = CW + 2 - F;
   localparam logic [XW-1:0] HI_THR = XW'(1) << (MANT_BITS - 1);
   localparam logic [RNW-1:0] SMAX = {{(RNW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [RNW-1:0] SMIN = {{(RNW - W + 1){1'b1}}, {(W - 1){1'b0}}};
   localparam logic [CW:0] HALF = (CW + 1)'(1) << (F - 1);

   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   // stage 1: cross product partial products
   logic signed [PW-1:0] cp_ff [6];
   logic [2:0][W-1:0]    m1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cp_ff[0] <= $signed(m_vec[1]) * $signed(s_vec[2]);
         cp_ff[1] <= $signed(m_vec[2]) * $signed(s_vec[1]);
         cp_ff[2] <= $signed(m_vec[2]) * $signed(s_vec[0]);
         cp_ff[3] <= $signed(m_vec[0]) * $signed(s_vec[2]);
         cp_ff[4] <= $signed(m_vec[0]) * $signed(s_vec[1]);
         cp_ff[5] <= $signed(m_vec[1]) * $signed(s_vec[0]);
         m1_ff    <= m_vec;
      end
   end

   // stage 2: difference, sign and magnitude
   logic signed [CW-1:0] c_in [3];
   logic [2:0]           neg_in;
   logic [XW-1:0]        mag_in [3];
   logic                 deg_in;

   always_comb begin
      c_in[0] = CW'(cp_ff[0]) - CW'(cp_ff[1]);
      c_in[1] = CW'(cp_ff[2]) - CW'(cp_ff[3]);
      c_in[2] = CW'(cp_ff[4]) - CW'(cp_ff[5]);
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = c_in[i][CW-1];
         mag_in[i] = XW'($unsigned(neg_in[i] ? -c_in[i] : c_in[i]));
      end
      deg_in = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
   end

   logic [XW-1:0]    nx_ff [NORM_STAGES+1][3];
   logic [XW-1:0]    nx_in [NORM_STAGES][3];
   logic [SIDEW-1:0] side_ff [SIDX+1];

   // normalisation: one power-of-two shift step per stage
   logic [XW-1:0] orv;
   logic [XW-1:0] lo_thr;
   int            shf;

   always_comb begin
      for (int g = 0; g < NORM_STAGES; g++) begin
         orv    = nx_ff[g][0] | nx_ff[g][1] | nx_ff[g][2];
         shf    = 1 << (NORM_STAGES - 1 - g);
         lo_thr = (shf < MANT_BITS) ? (XW'(1) << (MANT_BITS - shf)) : '0;
         for (int i = 0; i < 3; i++) begin
            if ((orv >> shf) >= HI_THR) begin
               nx_in[g][i] = nx_ff[g][i] >> shf;
            end else if (orv < lo_thr) begin
               nx_in[g][i] = nx_ff[g][i] << shf;
            end else begin
               nx_in[g][i] = nx_ff[g][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            nx_ff[0][i] <= mag_in[i];
         end
         for (int g = 0; g < NORM_STAGES; g++) begin
            for (int i = 0; i < 3; i++) begin
               nx_ff[g+1][i] <= nx_in[g][i];
            end
         end
         side_ff[0] <= {deg_in, neg_in, m1_ff};
         for (int k = 0; k < SIDX; k++) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // squares, sum and square root
   logic [2*MANT_BITS-1:0]   sq_ff [3];
   logic [3*MANT_BITS-1:0]   mnt_ff [ROOT_STAGES+2];
   logic [SQ_BITS-1:0]       rem_ff [ROOT_STAGES+1];
   logic [SQ_BITS-1:0]       res_ff [ROOT_STAGES+1];
   logic [SQ_BITS-1:0]       rem_in [ROOT_STAGES];
   logic [SQ_BITS-1:0]       res_in [ROOT_STAGES];
   logic [SQ_BITS-1:0]       bitv;
   logic [SQ_BITS:0]         trial;
   logic [MANT_BITS-1:0]     mant [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mant[i] = nx_ff[NORM_STAGES][i][MANT_BITS-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < ROOT_STAGES; k++) begin
         bitv  = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * k);
         trial = {1'b0, res_ff[k]} + {1'b0, bitv};
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_in[k] = rem_ff[k] - trial[SQ_BITS-1:0];
            res_in[k] = (res_ff[k] >> 1) + bitv;
         end else begin
            rem_in[k] = rem_ff[k];
            res_in[k] = res_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= mant[i] * mant[i];
         end
         mnt_ff[0] <= {mant[2], mant[1], mant[0]};
         for (int k = 0; k < ROOT_STAGES + 1; k++) begin
            mnt_ff[k+1] <= mnt_ff[k];
         end
         rem_ff[0] <= SQ_BITS'(sq_ff[0]) + SQ_BITS'(sq_ff[1]) + SQ_BITS'(sq_ff[2]);
         res_ff[0] <= '0;
         for (int k = 0; k < ROOT_STAGES; k++) begin
            rem_ff[k+1] <= rem_in[k];
            res_ff[k+1] <= res_in[k];
         end
      end
   end

   // rounded division by the root, one quotient bit per stage
   logic [ROOT_BITS-1:0] root;
   logic [DVW-1:0]       num_ff [QW+1][3];
   logic [ROOT_BITS-1:0] dr_ff [QW+1];
   logic [QW-1:0]        quo_ff [QW+1][3];
   logic [DVW-1:0]       num_in [QW][3];
   logic [QW-1:0]        quo_in [QW][3];
   logic [DVW-1:0]       dsub;
   logic [MANT_BITS-1:0] mfin [3];

   always_comb begin
      root = res_ff[ROOT_STAGES][ROOT_BITS-1:0];
      for (int i = 0; i < 3; i++) begin
         mfin[i] = mnt_ff[ROOT_STAGES+1][i*MANT_BITS +: MANT_BITS];
      end
   end

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         dsub = DVW'(dr_ff[k]) << (QW - 1 - k);
         for (int i = 0; i < 3; i++) begin
            quo_in[k][i] = quo_ff[k][i];
            if (num_ff[k][i] >= dsub) begin
               num_in[k][i]             = num_ff[k][i] - dsub;
               quo_in[k][i][QW - 1 - k] = 1'b1;
            end else begin
               num_in[k][i] = num_ff[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[0][i] <= (DVW'(mfin[i]) << F) + DVW'(root >> 1);
            quo_ff[0][i] <= '0;
         end
         dr_ff[0] <= root;
         for (int k = 0; k < QW; k++) begin
            dr_ff[k+1] <= dr_ff[k];
            for (int i = 0; i < 3; i++) begin
               num_ff[k+1][i] <= num_in[k][i];
               quo_ff[k+1][i] <= quo_in[k][i];
            end
         end
      end
   end

   // unit column, second cross product, rounding and saturation
   logic [SIDEW-1:0]     sd;
   logic [2:0][W-1:0]    u_in;
   logic signed [W-1:0]  uq;
   logic signed [PW-1:0] tp_ff [6];
   logic [2:0][W-1:0]    up_u_ff, up_m_ff;
   logic                 up_d_ff;
   logic signed [CW-1:0] td_ff [3];
   logic [2:0][W-1:0]    df_u_ff, df_m_ff;
   logic                 df_d_ff;
   logic [2:0][W-1:0]    c1_ff, c2_ff, c3_ff;
   logic                 cd_ff;

   always_comb begin
      sd = side_ff[SIDX];
      for (int i = 0; i < 3; i++) begin
         uq      = $signed(W'(quo_ff[QW][i]));
         u_in[i] = sd[3*W + i] ? -uq : uq;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tp_ff[0] <= $signed(sd[1*W +: W]) * $signed(u_in[2]);
         tp_ff[1] <= $signed(sd[2*W +: W]) * $signed(u_in[1]);
         tp_ff[2] <= $signed(sd[2*W +: W]) * $signed(u_in[0]);
         tp_ff[3] <= $signed(sd[0*W +: W]) * $signed(u_in[2]);
         tp_ff[4] <= $signed(sd[0*W +: W]) * $signed(u_in[1]);
         tp_ff[5] <= $signed(sd[1*W +: W]) * $signed(u_in[0]);
         up_u_ff  <= u_in;
         up_m_ff  <= sd[3*W-1:0];
         up_d_ff  <= sd[3*W+3];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         td_ff[0] <= CW'(tp_ff[0]) - CW'(tp_ff[1]);
         td_ff[1] <= CW'(tp_ff[2]) - CW'(tp_ff[3]);
         td_ff[2] <= CW'(tp_ff[4]) - CW'(tp_ff[5]);
         df_u_ff  <= up_u_ff;
         df_m_ff  <= up_m_ff;
         df_d_ff  <= up_d_ff;
      end
   end

   logic [2:0][W-1:0]     t_in;
   logic [CW-1:0]         tmag;
   logic [CW:0]           tsum;
   logic signed [RNW-1:0] tr;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tmag = $unsigned(td_ff[i][CW-1] ? -td_ff[i] : td_ff[i]);
         tsum = (CW + 1)'(tmag) + HALF;
         tr   = $signed(RNW'(tsum >> F));
         if (td_ff[i][CW-1]) begin
            tr = -tr;
         end
         if (tr > $signed(SMAX)) begin
            t_in[i] = SMAX[W-1:0];
         end else if (tr < $signed(SMIN)) begin
            t_in[i] = SMIN[W-1:0];
         end else begin
            t_in[i] = tr[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= df_m_ff;
         c2_ff <= df_u_ff;
         c3_ff <= t_in;
         cd_ff <= df_d_ff;
      end
   end

   assign col1       = c1_ff;
   assign col2       = c2_ff;
   assign col3       = c3_ff;
   assign stat.valid = vld_ff[LAT-1];
   assign stat.deg   = cd_ff;

endmodule

[sv/tam_checker.sv]
// ----------------------------------------------------------------------------
// tam_checker
// Port-level checks of the triad attitude matrix, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tam_checker #(
   parameter int DATA_WIDTH = 16
)
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_deg,
   input logic [9*DATA_WIDTH-1:0]      rsp_mat
);

   `TAM_ASSERT_R(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mat) && $stable(rsp_deg))
   `TAM_ASSERT_R(a_deg_zero, clock, reset, rsp_valid && rsp_deg |-> rsp_mat == '0)
   `TAM_ASSERT_R(a_stall_full, clock, reset, !req_ready |-> rsp_valid && !$past(req_valid && req_ready && !rsp_valid))
   `TAM_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind triad_attitude_matrix_top tam_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_deg   (rsp_chan.degenerate),
   .rsp_mat   ({rsp_chan.a22, rsp_chan.a21, rsp_chan.a20, rsp_chan.a12, rsp_chan.a11,
                rsp_chan.a10, rsp_chan.a02, rsp_chan.a01, rsp_chan.a00})
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TRIAD attitude matrix: a directed table of vector
// sets, then random sets, each predicted in fixed point or given a fixed result,
// compared field by field with the response channel under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import tam_pkg::*;

   localparam int DW       = 16;
   localparam int FRAC     = DW - 2;
   localparam int N_RANDOM = 1750;
   localparam int LATENCY  = DW + 48;
   localparam int LIMIT    = 400000;

   typedef logic signed [DW-1:0] word_type;

   typedef struct {
      word_type v[12];
   } vec_set_type;

   typedef struct {
      word_type a[9];
      logic     deg;
   } attitude_type;

   typedef struct {
      vec_set_type  vs;
      logic         typed;
      attitude_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle = 0;

   tam_req_if #(.DATA_WIDTH(DW)) req_chan ();
   tam_rsp_if #(.DATA_WIDTH(DW)) rsp_chan ();

   triad_attitude_matrix_top #(.DATA_WIDTH(DW)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   attitude_type pending_attitudes[$];
   int           mismatches = 0;
   bit           calm = 1'b0;

   function automatic longint round_q(longint x);
      longint m;
      m = ((x < 0 ? -x : x) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      return x < 0 ? -m : m;
   endfunction

   function automatic longint clamp_w(longint x);
      longint hi, lo;
      hi = (64'sd1 <<< (DW - 1)) - 1;
      lo = -(64'sd1 <<< (DW - 1));
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // col[k*3+i]: component i of frame column k
   function automatic bit build_frame(input longint m[3], input longint s[3],
                                      output longint col[9]);
      longint          c[3], u[3], t[3];
      longint unsigned mg[3], top, sq, r, q;
      int              k;
      c[0] = m[1]*s[2] - m[2]*s[1];
      c[1] = m[2]*s[0] - m[0]*s[2];
      c[2] = m[0]*s[1] - m[1]*s[0];
      top = 0;
      sq  = 0;
      k   = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i] = c[i] < 0 ? -c[i] : c[i];
         if (mg[i] > top) top = mg[i];
      end
      for (int i = 0; i < 9; i++) col[i] = 0;
      if (top == 0) return 1'b0;
      if (top >= (64'd1 << 30)) begin
         while ((top >> k) >= (64'd1 << 30)) k++;
         for (int i = 0; i < 3; i++) mg[i] >>= k;
      end else begin
         while ((top << k) < (64'd1 << 29)) k++;
         for (int i = 0; i < 3; i++) mg[i] <<= k;
      end
      for (int i = 0; i < 3; i++) sq += mg[i] * mg[i];
      r = int_root(sq);
      for (int i = 0; i < 3; i++) begin
         q    = ((mg[i] << FRAC) + (r >> 1)) / r;
         u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      t[0] = m[1]*u[2] - m[2]*u[1];
      t[1] = m[2]*u[0] - m[0]*u[2];
      t[2] = m[0]*u[1] - m[1]*u[0];
      for (int i = 0; i < 3; i++) begin
         col[i]   = m[i];
         col[3+i] = u[i];
         col[6+i] = clamp_w(round_q(t[i]));
      end
      return 1'b1;
   endfunction

   function automatic attitude_type predict_attitude(vec_set_type vs);
      attitude_type res;
      longint       rs[3], rm[3], ms[3], mm[3], mo[9], mr[9], acc;
      bit           ok_o, ok_r;
      for (int i = 0; i < 3; i++) begin
         rs[i] = vs.v[i];
         rm[i] = vs.v[3+i];
         ms[i] = vs.v[6+i];
         mm[i] = vs.v[9+i];
      end
      ok_o = build_frame(mm, ms, mo);
      ok_r = build_frame(rm, rs, mr);
      res.deg = !(ok_o && ok_r);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += round_q(mo[k*3+i] * mr[k*3+j]);
            res.a[i*3+j] = res.deg ? '0 : word_type'(clamp_w(acc));
         end
      end
      return res;
   endfunction

   function automatic vec_set_type make_set(int rsx, int rsy, int rsz, int rmx, int rmy,
                                            int rmz, int msx, int msy, int msz, int mmx,
                                            int mmy, int mmz);
      vec_set_type vs;
      vs.v = '{word_type'(rsx), word_type'(rsy), word_type'(rsz), word_type'(rmx),
               word_type'(rmy), word_type'(rmz), word_type'(msx), word_type'(msy),
               word_type'(msz), word_type'(mmx), word_type'(mmy), word_type'(mmz)};
      return vs;
   endfunction

   function automatic word_type rand_comp(bit unit_scale);
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return word_type'(16'sh7FFF);
      if (sel == 1) return word_type'(16'sh8000);
      if (sel == 2) return '0;
      if (unit_scale) return word_type'($urandom_range(0, 32768) - 16384);
      return word_type'($urandom);
   endfunction

   function automatic vec_set_type rand_set();
      vec_set_type vs;
      int          mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++) vs.v[i] = rand_comp(mode < 7);
      // measured sun from measured magnetic with random signs, or zero ref magnetic, now and then
      if (mode == 9) begin
         for (int i = 0; i < 3; i++) vs.v[6+i] = ($urandom_range(0, 1) != 0) ?
                                                  vs.v[9+i] : -vs.v[9+i];
      end
      if (mode == 8) begin
         for (int i = 0; i < 3; i++) vs.v[3+i] = '0;
      end
      return vs;
   endfunction

   function automatic attitude_type zero_degenerate();
      attitude_type z;
      foreach (z.a[i]) z.a[i] = '0;
      z.deg = 1'b1;
      return z;
   endfunction

   function automatic attitude_type identity_q();
      attitude_type e;
      foreach (e.a[i]) e.a[i] = '0;
      e.a[0] = word_type'(16384);
      e.a[4] = word_type'(16384);
      e.a[8] = word_type'(16384);
      e.deg  = 1'b0;
      return e;
   endfunction

   row_type directed[$];

   task automatic add_row(vec_set_type vs, bit typed, attitude_type want);
      row_type r;
      r.vs    = vs;
      r.typed = typed;
      r.want  = want;
      directed.push_back(r);
   endtask

   task automatic send_set(vec_set_type vs, attitude_type want);
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.ref_sun_x  <= vs.v[0];
      req_chan.ref_sun_y  <= vs.v[1];
      req_chan.ref_sun_z  <= vs.v[2];
      req_chan.ref_mag_x  <= vs.v[3];
      req_chan.ref_mag_y  <= vs.v[4];
      req_chan.ref_mag_z  <= vs.v[5];
      req_chan.meas_sun_x <= vs.v[6];
      req_chan.meas_sun_y <= vs.v[7];
      req_chan.meas_sun_z <= vs.v[8];
      req_chan.meas_mag_x <= vs.v[9];
      req_chan.meas_mag_y <= vs.v[10];
      req_chan.meas_mag_z <= vs.v[11];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_attitudes.push_back(want);
   endtask

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 29);
   end

   always @(posedge clock) begin
      attitude_type got, want;
      bit           bad;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.a   = '{rsp_chan.a00, rsp_chan.a01, rsp_chan.a02, rsp_chan.a10,
                     rsp_chan.a11, rsp_chan.a12, rsp_chan.a20, rsp_chan.a21,
                     rsp_chan.a22};
         got.deg = rsp_chan.degenerate;
         if (pending_attitudes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycle);
         end else begin
            want = pending_attitudes.pop_front();
            bad  = (got.deg !== want.deg);
            for (int i = 0; i < 9; i++) begin
               if (got.a[i] !== want.a[i]) bad = 1'b1;
            end
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at cycle %0d, degenerate exp %b got %b", cycle,
                           want.deg, got.deg);
                  for (int i = 0; i < 9; i++)
                     $display("  a%0d%0d exp %0d got %0d", i / 3, i % 3, want.a[i],
                              got.a[i]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle >= LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      attitude_type want;
      int           drain;
      req_chan.valid <= 1'b0;
      req_chan.ref_sun_x <= '0;  req_chan.ref_sun_y <= '0;  req_chan.ref_sun_z <= '0;
      req_chan.ref_mag_x <= '0;  req_chan.ref_mag_y <= '0;  req_chan.ref_mag_z <= '0;
      req_chan.meas_sun_x <= '0; req_chan.meas_sun_y <= '0; req_chan.meas_sun_z <= '0;
      req_chan.meas_mag_x <= '0; req_chan.meas_mag_y <= '0; req_chan.meas_mag_z <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // identity: same frames, unit axes
      add_row(make_set(0, 16384, 0, 16384, 0, 0, 0, 16384, 0, 16384, 0, 0), 1,
              identity_q());
      add_row(make_set(0, 0, 16384, 0, 16384, 0, 0, 0, 16384, 0, 16384, 0), 1,
              identity_q());
      // degenerate: zero vectors, parallel pairs
      add_row(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_degenerate());
      add_row(make_set(0, 16384, 0, 16384, 0, 0, 100, 0, 0, 200, 0, 0), 1,
              zero_degenerate());
      add_row(make_set(5, 5, 5, -5, -5, -5, 0, 16384, 0, 16384, 0, 0), 1,
              zero_degenerate());
      add_row(make_set(0, 16384, 0, 0, 0, 0, 0, 16384, 0, 16384, 0, 0), 1,
              zero_degenerate());
      // extremes, saturation and small or mixed sets
      add_row(make_set(32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768,
                       -32768, -32768, 32767, -32768), 0, want);
      add_row(make_set(-32768, 0, 0, 0, -32768, 0, 0, 32767, 0, 32767, 0, 0), 0, want);
      add_row(make_set(32767, 32767, 0, 32767, 0, 32767, -32768, -32768, 0, 0,
                       -32768, -32768), 0, want);
      add_row(make_set(1, 0, 0, 0, 1, 0, 0, 1, 0, 1, 0, 0), 0, want);
      add_row(make_set(1, 2, 3, -3, 2, -1, 11585, 11585, 0, 0, 0, 16384), 0, want);
      add_row(make_set(-1, -1, -1, -1, -1, -2, -1, -1, -1, -2, -1, -1), 0, want);
      add_row(make_set(9459, 9459, 9459, 16384, 0, 0, -9459, 9459, 9459, 0, -16384, 0),
              0, want);
      add_row(make_set(32767, 32767, 32767, -32768, 32767, 0, 32767, 0, -32768,
                       -32768, -32768, -32768), 0, want);
      foreach (directed[i]) begin
         want = directed[i].typed ? directed[i].want : predict_attitude(directed[i].vs);
         send_set(directed[i].vs, want);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         vec_set_type vs;
         calm = (n >= 600 && n < 800);
         vs = rand_set();
         send_set(vs, predict_attitude(vs));
      end
      req_chan.valid <= 1'b0;
      calm = 1'b0;
      while (pending_attitudes.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < 2 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      if (mismatches == 0 && pending_attitudes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/tam_pkg.sv
sv/tam_req_if.sv
sv/tam_rsp_if.sv
sv/tam_frame.sv
sv/triad_attitude_matrix_top.sv
sv/tam_checker.sv
verif/tb.sv
